// ===== rtl/kfwt_pkg.sv =====
package kfwt_pkg;

    // Operation codes carried on i_op
    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;
    localparam logic [1:0] OP_LOOKUP = 2'd3;

    // Status codes returned on o_status
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_NOKEY = 2'd3;

    // One stored record; val caches count times price
    typedef struct packed {
        logic [15:0] key;
        logic [31:0] arr_time;
        logic [15:0] count;
        logic [15:0] price;
        logic [31:0] val;
    } t_rec;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic        eval;
        logic        pop;
        logic [15:0] key;
        logic        shift;
        logic        push;
    } t_cell_ctl;

endpackage

// ===== rtl/kfwt_cell.sv =====
module kfwt_cell #(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kfwt_pkg::t_cell_ctl i_ctl,
    input  logic               i_active,
    input  logic               i_at_tail,
    input  logic               i_found,
    input  kfwt_pkg::t_rec     i_next,
    input  kfwt_pkg::t_rec     i_wdata,
    output logic               o_found,
    output logic               o_first,
    output kfwt_pkg::t_rec     o_rec
);
    import kfwt_pkg::*;

    t_rec r_rec;
    logic r_rm;
    logic w_hit;

    // Pop always hits the head cell; other ops compare keys
    assign w_hit   = i_active & (i_ctl.pop ? (IDX == 0) : (r_rec.key == i_ctl.key));
    assign o_first = w_hit & ~i_found;
    assign o_found = i_found | w_hit;
    assign o_rec   = r_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rm <= 1'b0;
        end else if (i_ctl.eval) begin
            r_rm <= o_found;
        end
    end

    // Take the neighbor's record when the removal point is at or below this cell
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift && r_rm) begin
            r_rec <= i_next;
        end else if (i_ctl.push && i_at_tail) begin
            r_rec <= i_wdata;
        end
    end

endmodule

// ===== rtl/keyed_fifo_with_totals_core.sv =====
// Each transaction passes an evaluate step, which runs the key match chain across
// all cells, then an apply step, which applies the shift or write and totals and
// registers the result; the next transaction can be accepted as the apply step goes.
// A stalled result holds the block in its apply step until it is taken.
// Reset (i_rst_n, synchronous, active low) clears occupancy, both totals and the
// handshake state; record contents in the cells are left as they are.
module keyed_fifo_with_totals_core #(
    parameter int DEPTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_op,
    input  logic [15:0]                   i_entry_key,
    input  logic [31:0]                   i_arrival_time,
    input  logic [15:0]                   i_item_count,
    input  logic [15:0]                   i_unit_price,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic [15:0]                   o_out_key,
    output logic [31:0]                   o_out_arrival_time,
    output logic [15:0]                   o_out_item_count,
    output logic [15:0]                   o_out_unit_price,
    output logic [31:0]                   o_entry_value,
    output logic [$clog2(DEPTH+1)-1:0]    o_occupancy,
    output logic [16+$clog2(DEPTH)-1:0]   o_total_items,
    output logic [32+$clog2(DEPTH)-1:0]   o_total_value
);
    import kfwt_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);     // occupancy width
    localparam int IW = 16 + $clog2(DEPTH);    // item total width
    localparam int VW = 32 + $clog2(DEPTH);    // value total width

    typedef enum logic [1:0] {S_IDLE, S_EVAL, S_APPLY} t_state;

    t_state r_state;

    // Accepted command
    logic [1:0]  r_op;
    logic [15:0] r_key;
    logic [31:0] r_time;
    logic [15:0] r_cnt;
    logic [15:0] r_prc;

    // Evaluation results
    logic [31:0] r_prod;
    logic        r_found;
    t_rec        r_sel;

    // Architectural totals
    logic [CW-1:0] r_fill;
    logic [IW-1:0] r_isum;
    logic [VW-1:0] r_vsum;

    // Output register
    logic          r_out_valid;
    logic [1:0]    r_status;
    t_rec          r_out_rec;
    logic [31:0]   r_out_val;

    logic          w_in_acc;
    logic          w_apply_go;
    logic          w_full;
    logic          w_empty;
    t_cell_ctl     w_ctl;
    t_rec          w_wdata;
    t_rec          w_sel;
    logic          w_any;
    logic [DEPTH:0] w_found;
    logic [DEPTH-1:0] w_first;
    t_rec          w_rec  [DEPTH];
    t_rec          w_next [DEPTH];

    // Apply only when the output register is free or drains this cycle
    assign w_apply_go = (r_state == S_APPLY) && (!r_out_valid || !i_out_stall);
    assign o_in_stall = !((r_state == S_IDLE) || w_apply_go);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign w_full  = (r_fill == CW'(DEPTH));
    assign w_empty = (r_fill == '0);

    // Broadcast control to the chain
    always_comb begin
        w_ctl.eval  = (r_state == S_EVAL);
        w_ctl.pop   = (r_op == OP_POP);
        w_ctl.key   = r_key;
        w_ctl.shift = w_apply_go && r_found && ((r_op == OP_POP) || (r_op == OP_CANCEL));
        w_ctl.push  = w_apply_go && (r_op == OP_PUSH) && !w_full;
    end

    assign w_wdata = '{key: r_key, arr_time: r_time, count: r_cnt, price: r_prc, val: r_prod};

    assign w_found[0] = 1'b0;

    // Cell i takes from cell i+1; the last cell takes filler past the tail
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_next[i] = (i == DEPTH - 1) ? t_rec'('0) : w_rec[(i + 1) % DEPTH];
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            kfwt_cell #(.IDX(g)) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (w_ctl),
                .i_active  (CW'(g) < r_fill),
                .i_at_tail (CW'(g) == r_fill),
                .i_found   (w_found[g]),
                .i_next    (w_next[g]),
                .i_wdata   (w_wdata),
                .o_found   (w_found[g+1]),
                .o_first   (w_first[g]),
                .o_rec     (w_rec[g])
            );
        end
    endgenerate

    // Gather the first matching record; at most one cell flags first
    always_comb begin
        w_sel = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_sel = w_sel | (w_first[i] ? w_rec[i] : t_rec'('0));
        end
    end
    assign w_any = w_found[DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_isum      <= '0;
            r_vsum      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the presented result once taken, unless a new one replaces it
            if (o_out_valid && !i_out_stall && !w_apply_go) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_prod  <= r_cnt * r_prc;
                    r_found <= w_any;
                    r_sel   <= w_sel;
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    if (w_apply_go) begin
                        r_out_valid <= 1'b1;
                        case (r_op)
                            OP_PUSH: begin
                                r_out_rec <= '0;
                                r_out_val <= '0;
                                if (w_full) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_status <= ST_OK;
                                    r_fill   <= r_fill + CW'(1);
                                    r_isum   <= r_isum + IW'(r_cnt);
                                    r_vsum   <= r_vsum + VW'(r_prod);
                                end
                            end
                            OP_POP: begin
                                if (w_empty) begin
                                    r_status  <= ST_EMPTY;
                                    r_out_rec <= '0;
                                    r_out_val <= '0;
                                end else begin
                                    r_status  <= ST_OK;
                                    r_out_rec <= r_sel;
                                    r_out_val <= r_sel.val;
                                    r_fill    <= r_fill - CW'(1);
                                    r_isum    <= r_isum - IW'(r_sel.count);
                                    r_vsum    <= r_vsum - VW'(r_sel.val);
                                end
                            end
                            OP_CANCEL: begin
                                r_out_rec <= '0;
                                r_out_val <= '0;
                                if (w_empty) begin
                                    r_status <= ST_EMPTY;
                                end else if (!r_found) begin
                                    r_status <= ST_NOKEY;
                                end else begin
                                    r_status <= ST_OK;
                                    r_fill   <= r_fill - CW'(1);
                                    r_isum   <= r_isum - IW'(r_sel.count);
                                    r_vsum   <= r_vsum - VW'(r_sel.val);
                                end
                            end
                            default: begin
                                // look up: report value, change nothing
                                r_out_rec <= '0;
                                if (r_found) begin
                                    r_status  <= ST_OK;
                                    r_out_val <= r_sel.val;
                                end else begin
                                    r_status  <= ST_NOKEY;
                                    r_out_val <= '0;
                                end
                            end
                        endcase
                        r_state <= w_in_acc ? S_EVAL : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Capture the command on acceptance
            if (w_in_acc) begin
                r_op   <= i_op;
                r_key  <= i_entry_key;
                r_time <= i_arrival_time;
                r_cnt  <= i_item_count;
                r_prc  <= i_unit_price;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_out_key          = r_out_rec.key;
    assign o_out_arrival_time = r_out_rec.arr_time;
    assign o_out_item_count   = r_out_rec.count;
    assign o_out_unit_price   = r_out_rec.price;
    assign o_entry_value      = r_out_val;
    assign o_occupancy        = r_fill;
    assign o_total_items      = r_isum;
    assign o_total_value      = r_vsum;

endmodule

// ===== rtl/kfwt_checker.sv =====
module kfwt_checker #(
    parameter int DEPTH = 32
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [1:0]                    o_status,
    input logic [31:0]                   o_entry_value,
    input logic [$clog2(DEPTH+1)-1:0]    o_occupancy,
    input logic [16+$clog2(DEPTH)-1:0]   o_total_items,
    input logic [32+$clog2(DEPTH)-1:0]   o_total_value
);
    import kfwt_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    // A held result keeps its status
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status))
        else $error("stalled result changed");

    // Occupancy never exceeds capacity
    a_occ_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_occupancy <= CW'(DEPTH))
        else $error("occupancy above depth");

    // Full status only with a full list
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL) |-> o_occupancy == CW'(DEPTH))
        else $error("full status with room left");

    // Empty status reports nothing held and no value
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_EMPTY) |->
            (o_occupancy == '0) && (o_entry_value == '0))
        else $error("empty status with records held");

    // With no records held the totals are zero
    a_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_occupancy == '0) |->
            (o_total_items == '0) && (o_total_value == '0))
        else $error("totals nonzero with no records");

endmodule

bind keyed_fifo_with_totals_core kfwt_checker #(.DEPTH(DEPTH)) u_kfwt_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import kfwt_pkg::*;

    localparam int FIFO_DEPTH       = 32;
    localparam int RANDOM_PER_PHASE = 517;  // three phases, about 1550 random transactions
    localparam int WATCHDOG_LIMIT   = 2000; // cycles in which no transaction is accepted and no result is taken
    localparam int SETTLE_CYCLES    = 8;    // settle margin after the last result

    // One input transaction and one result, at the widths of the ports
    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] key;
        logic [31:0] arr;
        logic [15:0] cnt;
        logic [15:0] prc;
    } t_fifo_txn;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] rkey;
        logic [31:0] rarr;
        logic [15:0] rcnt;
        logic [15:0] rprc;
        logic [31:0] val;
        logic [5:0]  occ;
        logic [20:0] items;
        logic [36:0] value;
    } t_fifo_res;

    typedef struct packed {
        logic [15:0] key;
        logic [31:0] arr;
        logic [15:0] cnt;
        logic [15:0] prc;
    } t_held_rec;

    // A row of the directed table; fixed rows carry a hand-typed result
    typedef struct packed {
        t_fifo_txn txn;
        logic      fixed;
        t_fifo_res res;
    } t_directed_row;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [1:0]  i_op           = OP_PUSH;
    logic [15:0] i_entry_key    = '0;
    logic [31:0] i_arrival_time = '0;
    logic [15:0] i_item_count   = '0;
    logic [15:0] i_unit_price   = '0;
    logic        i_out_stall    = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic [15:0] o_out_key;
    logic [31:0] o_out_arrival_time;
    logic [15:0] o_out_item_count;
    logic [15:0] o_out_unit_price;
    logic [31:0] o_entry_value;
    logic [5:0]  o_occupancy;
    logic [20:0] o_total_items;
    logic [36:0] o_total_value;

    // Predictor state: the held records, head first, and the running totals
    t_held_rec     held_recs[$];
    logic [20:0]   held_items;
    logic [36:0]   held_value;
    t_fifo_res     pending_results[$];
    t_directed_row directed_rows[$];

    int in_idle_pct;
    int out_idle_pct;
    int idle_cycles;
    int txns_sent;
    int results_checked;
    int mismatches;
    int n_full;
    int n_empty;
    int n_nokey;
    int peak_occ;
    logic [15:0] key_base;

    keyed_fifo_with_totals_core #(
        .DEPTH(FIFO_DEPTH)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_op               (i_op),
        .i_entry_key        (i_entry_key),
        .i_arrival_time     (i_arrival_time),
        .i_item_count       (i_item_count),
        .i_unit_price       (i_unit_price),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_status           (o_status),
        .o_out_key          (o_out_key),
        .o_out_arrival_time (o_out_arrival_time),
        .o_out_item_count   (o_out_item_count),
        .o_out_unit_price   (o_out_unit_price),
        .o_entry_value      (o_entry_value),
        .o_occupancy        (o_occupancy),
        .o_total_items      (o_total_items),
        .o_total_value      (o_total_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] rec_value(input logic [15:0] cnt, input logic [15:0] prc);
        return 32'(cnt) * 32'(prc);
    endfunction

    // Apply one transaction to the predictor state and return the result it causes.
    // Matching always picks the first record from the head, as the block does.
    function automatic t_fifo_res predict_fifo_op(input t_fifo_txn t);
        t_fifo_res r;
        t_held_rec h;
        int idx;
        int i;
        r = '0;
        idx = -1;
        for (i = 0; i < held_recs.size(); i++) begin
            if (idx < 0 && held_recs[i].key == t.key) idx = i;
        end
        case (t.op)
            OP_PUSH: begin
                if (held_recs.size() >= FIFO_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    held_recs.push_back('{t.key, t.arr, t.cnt, t.prc});
                    held_items = held_items + 21'(t.cnt);
                    held_value = held_value + 37'(rec_value(t.cnt, t.prc));
                end
            end
            OP_POP: begin
                if (held_recs.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    h = held_recs.pop_front();
                    r.rkey = h.key;
                    r.rarr = h.arr;
                    r.rcnt = h.cnt;
                    r.rprc = h.prc;
                    r.val  = rec_value(h.cnt, h.prc);
                    held_items = held_items - 21'(h.cnt);
                    held_value = held_value - 37'(r.val);
                end
            end
            OP_CANCEL: begin
                // An empty list reports empty before any key search
                if (held_recs.size() == 0) begin
                    r.status = ST_EMPTY;
                end else if (idx < 0) begin
                    r.status = ST_NOKEY;
                end else begin
                    h = held_recs[idx];
                    held_recs.delete(idx);
                    held_items = held_items - 21'(h.cnt);
                    held_value = held_value - 37'(rec_value(h.cnt, h.prc));
                end
            end
            default: begin
                if (idx < 0) r.status = ST_NOKEY;
                else r.val = rec_value(held_recs[idx].cnt, held_recs[idx].prc);
            end
        endcase
        case (r.status)
            ST_FULL:  n_full++;
            ST_EMPTY: n_empty++;
            ST_NOKEY: n_nokey++;
            default:  ;
        endcase
        if (held_recs.size() > peak_occ) peak_occ = held_recs.size();
        r.occ   = 6'(held_recs.size());
        r.items = held_items;
        r.value = held_value;
        return r;
    endfunction

    function automatic logic [15:0] pick16();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    // Drive one transaction and hold it until accepted; then advance the predictor.
    // Drop valid for a random gap first when the sender idles.
    task automatic send_txn(input t_fifo_txn t, output t_fifo_res want);
        int gap;
        if ($urandom_range(99) < in_idle_pct) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_op           <= t.op;
        i_entry_key    <= t.key;
        i_arrival_time <= t.arr;
        i_item_count   <= t.cnt;
        i_unit_price   <= t.prc;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        want = predict_fifo_op(t);
        txns_sent++;
    endtask

    task automatic add_row(input t_fifo_txn t, input logic fixed, input t_fifo_res res);
        directed_rows.push_back('{t, fixed, res});
    endtask

    // One random episode: a fill burst up to full and past it, a drain burst past
    // empty, or a short mix of all operations. Keys mostly come from a small pool
    // so that cancel and look up find their records.
    task automatic run_episode();
        t_fifo_txn t;
        t_fifo_res want;
        int kind;
        int n;
        kind = $urandom_range(9);
        if (kind < 2) n = FIFO_DEPTH - held_recs.size() + $urandom_range(0, 4);
        else if (kind < 4) n = held_recs.size() + $urandom_range(0, 3);
        else n = $urandom_range(8, 24);
        repeat (n) begin
            if (kind < 2) t.op = OP_PUSH;
            else if (kind < 4) t.op = ($urandom_range(4) == 0) ? OP_CANCEL : OP_POP;
            else t.op = 2'($urandom_range(3));
            t.key = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                             : key_base ^ 16'($urandom_range(7));
            t.arr = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : 32'($urandom());
            t.cnt = pick16();
            t.prc = pick16();
            send_txn(t, want);
            pending_results.push_back(want);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] %s mismatch: expected 0x%0h, got 0x%0h", $realtime, name,
                         want, got);
        end
    endtask

    // Result side: compare every accepted result with the oldest expectation,
    // then draw the stall for the next cycle.
    always @(posedge i_clk) begin
        t_fifo_res want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] result with no transaction outstanding", $realtime);
                end else begin
                    want = pending_results.pop_front();
                    results_checked++;
                    check_field("status",           o_status,           want.status);
                    check_field("out_key",          o_out_key,          want.rkey);
                    check_field("out_arrival_time", o_out_arrival_time, want.rarr);
                    check_field("out_item_count",   o_out_item_count,   want.rcnt);
                    check_field("out_unit_price",   o_out_unit_price,   want.rprc);
                    check_field("entry_value",      o_entry_value,      want.val);
                    check_field("occupancy",        o_occupancy,        want.occ);
                    check_field("total_items",      o_total_items,      want.items);
                    check_field("total_value",      o_total_value,      want.value);
                end
            end
            i_out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    // Watchdog: count cycles in which neither side moves a transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending_results.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        t_fifo_res want;
        int phase;
        idle_cycles     = 0;
        txns_sent       = 0;
        results_checked = 0;
        mismatches      = 0;
        n_full          = 0;
        n_empty         = 0;
        n_nokey         = 0;
        peak_occ        = 0;
        held_items      = '0;
        held_value      = '0;
        in_idle_pct     = 26;
        out_idle_pct    = 66;
        key_base        = 16'($urandom_range(65535));

        // Hold reset, then release it once for the whole run
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty list first, then the widest record, a null record,
        // misses on an occupied list, duplicate keys, cancel at head, middle and tail
        add_row('{OP_POP, 16'h0, 32'h0, 16'h0, 16'h0}, 1'b1,
                '{ST_EMPTY, 0, 0, 0, 0, 0, 0, 0, 0});
        add_row('{OP_CANCEL, 16'h0, 32'h0, 16'h0, 16'h0}, 1'b1,
                '{ST_EMPTY, 0, 0, 0, 0, 0, 0, 0, 0});
        add_row('{OP_LOOKUP, 16'h0, 32'h0, 16'h0, 16'h0}, 1'b1,
                '{ST_NOKEY, 0, 0, 0, 0, 0, 0, 0, 0});
        add_row('{OP_PUSH, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
                '{ST_OK, 0, 0, 0, 0, 0, 1, 21'd65535, 37'd4294836225});
        add_row('{OP_PUSH, 16'h0, 32'h0, 16'h0, 16'h0}, 1'b1,
                '{ST_OK, 0, 0, 0, 0, 0, 2, 21'd65535, 37'd4294836225});
        add_row('{OP_LOOKUP, 16'hFFFF, 32'h0, 16'h0, 16'h0}, 1'b1,
                '{ST_OK, 0, 0, 0, 0, 32'hFFFE_0001, 2, 21'd65535, 37'd4294836225});
        add_row('{OP_LOOKUP, 16'h1234, 32'h0, 16'h0, 16'h0}, 1'b1,
                '{ST_NOKEY, 0, 0, 0, 0, 0, 2, 21'd65535, 37'd4294836225});
        add_row('{OP_CANCEL, 16'h1234, 32'h0, 16'h0, 16'h0}, 1'b1,
                '{ST_NOKEY, 0, 0, 0, 0, 0, 2, 21'd65535, 37'd4294836225});
        add_row('{OP_POP, 16'h0, 32'h0, 16'h0, 16'h0}, 1'b1,
                '{ST_OK, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFE_0001,
                  1, 0, 0});
        add_row('{OP_LOOKUP, 16'h0, 32'h0, 16'h0, 16'h0}, 1'b1,
                '{ST_OK, 0, 0, 0, 0, 0, 1, 0, 0});
        add_row('{OP_CANCEL, 16'h0, 32'h0, 16'h0, 16'h0}, 1'b1,
                '{ST_OK, 0, 0, 0, 0, 0, 0, 0, 0});
        add_row('{OP_PUSH,   16'h0005, 32'd100,        16'd3,     16'd7},     1'b0, '0);
        add_row('{OP_PUSH,   16'h0005, 32'd200,        16'd2,     16'd9},     1'b0, '0);
        add_row('{OP_PUSH,   16'hAAAA, 32'hDEAD_BEEF,  16'h1234,  16'h5678},  1'b0, '0);
        add_row('{OP_PUSH,   16'h5555, 32'h1234_5678,  16'hFFFF,  16'h0001},  1'b0, '0);
        add_row('{OP_LOOKUP, 16'h0005, 32'h0,          16'h0,     16'h0},     1'b0, '0);
        add_row('{OP_CANCEL, 16'h0005, 32'h0,          16'h0,     16'h0},     1'b0, '0);
        add_row('{OP_LOOKUP, 16'h0005, 32'h0,          16'h0,     16'h0},     1'b0, '0);
        add_row('{OP_CANCEL, 16'h5555, 32'h0,          16'h0,     16'h0},     1'b0, '0);
        add_row('{OP_PUSH,   16'h0000, 32'h8000_0000,  16'h8000,  16'h8000},  1'b0, '0);
        add_row('{OP_CANCEL, 16'hAAAA, 32'h0,          16'h0,     16'h0},     1'b0, '0);
        add_row('{OP_LOOKUP, 16'h0000, 32'h0,          16'h0,     16'h0},     1'b0, '0);
        add_row('{OP_POP,    16'h0,    32'h0,          16'h0,     16'h0},     1'b0, '0);
        add_row('{OP_POP,    16'h0,    32'h0,          16'h0,     16'h0},     1'b0, '0);
        add_row('{OP_POP,    16'h0,    32'h0,          16'h0,     16'h0},     1'b0, '0);

        foreach (directed_rows[k]) begin
            send_txn(directed_rows[k].txn, want);
            if (directed_rows[k].fixed) want = directed_rows[k].res;
            pending_results.push_back(want);
        end

        // Random part in three phases: sender idles lightly while the receiver
        // stalls heavily, then the reverse, then full rate on both sides
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin in_idle_pct = 26; out_idle_pct = 66; end
                1: begin in_idle_pct = 66; out_idle_pct = 26; end
                default: begin in_idle_pct = 0; out_idle_pct = 0; end
            endcase
            key_base = 16'($urandom_range(65535));
            while (txns_sent < directed_rows.size() + (phase + 1) * RANDOM_PER_PHASE)
                run_episode();
        end

        // Drain: release the input, wait for every result, then let the outputs settle
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d transactions (%0d directed), checked %0d results, peak occupancy %0d",
                 txns_sent, directed_rows.size(), results_checked, peak_occ);
        $display("Rejections seen: %0d full, %0d empty, %0d key not found; %0d mismatches",
                 n_full, n_empty, n_nokey, mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
